// ===== hdl/gkdr_pkg.sv =====
// shared constants, codes and types for the gated key debounce reporter
`default_nettype none
package gkdr_pkg;

	localparam int NUM_KEYS = 15;
	localparam int KEY_W = 4;
	localparam int CNT_W = 4;
	localparam int LEVELS_W = 15;
	localparam int KEY_IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 8;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic CMD_SCAN = 1'b0;
	localparam logic CMD_SERVICE = 1'b1;

	localparam logic REG_PRESS_THRESHOLD = 1'b0;
	localparam logic REG_GATE_KEY = 1'b1;

	localparam logic [CNT_W-1:0] THRESHOLD_RESET = CNT_W'(3);
	localparam logic [KEY_W-1:0] GATE_KEY_RESET = KEY_W'(1);
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	localparam int RES_VALID_BIT = 0;
	localparam int RES_CODE_LSB = 1;
	localparam int RES_DOWN_BIT = RES_CODE_LSB + KEY_W;

	typedef struct packed {
		logic confirmed;
		logic armed;
		logic change;
	} lane_out_t;

	typedef struct packed {
		logic [NUM_KEYS-1:0] confirmed;
		logic [NUM_KEYS-1:0] armed;
		logic [NUM_KEYS-1:0] change;
	} key_status_t;

	typedef struct packed {
		logic report_valid;
		logic [KEY_W-1:0] key_code;
		logic key_down;
	} result_t;

endpackage
`default_nettype wire

// ===== hdl/gated_key_debounce_reporter_top.sv =====
// top level: config registers, key lanes, merge stage and output register
//
// Debounces NUM_KEYS active-low keys and reports confirmed changes while the
// gate key is held. Every request (scan with key levels, or service) gives
// exactly one result in the cycle after it is accepted; a new request is
// taken every cycle while the output register is empty or being drained, so
// the block sustains one request per clock. All keys are handled by their own
// lane in the accepting cycle; the limit is the one-entry output register.
// Configuration registers: press_threshold at 0x0, gate_key at 0x4.
`default_nettype none
module gated_key_debounce_reporter_top (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic s_tready,
	input  wire logic [gkdr_pkg::S_TDATA_W-1:0] s_tdata, // key_levels[14:0], zero
	input  wire logic s_tuser, // command
	output logic m_tvalid,
	input  wire logic m_tready,
	output logic [gkdr_pkg::M_TDATA_W-1:0] m_tdata, // report_valid, key_code[3:0], key_down, zeros
	input  wire logic psel,
	input  wire logic penable,
	input  wire logic pwrite,
	input  wire logic [gkdr_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [gkdr_pkg::APB_DATA_W-1:0] pwdata,
	output logic [gkdr_pkg::APB_DATA_W-1:0] prdata,
	output logic pready
);
	import gkdr_pkg::*;

	logic [CNT_W-1:0] threshold_q;
	logic [KEY_W-1:0] gate_key_q;
	logic reg_sel;
	logic cfg_wr;
	logic accept;
	logic scan_en;
	logic srv_en;
	logic [LEVELS_W-1:0] key_levels;
	logic [NUM_KEYS-1:0] clr_armed;
	key_status_t status;
	result_t result;
	logic out_valid_q;
	result_t out_res_q;

	// apb registers, word aligned
	assign pready = 1'b1;
	assign reg_sel = paddr[2];
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
			gate_key_q <= GATE_KEY_RESET;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_PRESS_THRESHOLD: threshold_q <= pwdata[CNT_W-1:0];
				REG_GATE_KEY: gate_key_q <= pwdata[KEY_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_PRESS_THRESHOLD: prdata = APB_DATA_W'(threshold_q);
			REG_GATE_KEY: prdata = APB_DATA_W'(gate_key_q);
			default: prdata = '0;
		endcase
	end

	// request handshake
	assign s_tready = !out_valid_q || m_tready;
	assign accept = s_tvalid && s_tready;
	assign scan_en = accept && (s_tuser == CMD_SCAN);
	assign srv_en = accept && (s_tuser == CMD_SERVICE);
	assign key_levels = s_tdata[LEVELS_W-1:0];

	for (genvar i = 0; i < NUM_KEYS; i++) begin : g_lane
		lane_out_t lane_out;

		gkdr_lane u_lane (
			.clk(clk),
			.arst_n(arst_n),
			.scan_en(scan_en),
			.level(key_levels[i]),
			.press_threshold(threshold_q),
			.clr_armed(clr_armed[i]),
			.lane_out(lane_out)
		);

		assign status.confirmed[i] = lane_out.confirmed;
		assign status.armed[i] = lane_out.armed;
		assign status.change[i] = lane_out.change;
	end

	gkdr_merge u_merge (
		.clk(clk),
		.arst_n(arst_n),
		.scan_en(scan_en),
		.srv_en(srv_en),
		.gate_key(gate_key_q),
		.status(status),
		.clr_armed(clr_armed),
		.result(result)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_res_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata[RES_VALID_BIT] = out_res_q.report_valid;
	assign m_tdata[RES_CODE_LSB +: KEY_W] = out_res_q.key_code;
	assign m_tdata[RES_DOWN_BIT] = out_res_q.key_down;
	assign m_tdata[M_TDATA_W-1:RES_DOWN_BIT+1] = '0;

endmodule
`default_nettype wire

// ===== hdl/gkdr_lane.sv =====
// debounce cell for one key: press counter, confirmed state and report flag
`default_nettype none
module gkdr_lane (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic scan_en,
	input  wire logic level,
	input  wire logic [gkdr_pkg::CNT_W-1:0] press_threshold,
	input  wire logic clr_armed,
	output gkdr_pkg::lane_out_t lane_out
);
	import gkdr_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic confirmed_q;
	logic armed_q;
	logic down;
	logic [CNT_W-1:0] count_inc;
	logic press_hit;
	logic release_hit;

	assign down = ~level;
	assign count_inc = (count_q == CNT_MAX) ? CNT_MAX : count_q + CNT_W'(1);
	assign press_hit = down && !confirmed_q && (count_inc >= press_threshold);
	assign release_hit = !down && confirmed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			confirmed_q <= 1'b0;
			armed_q <= 1'b0;
		end else if (scan_en) begin
			if (down) begin
				if (!confirmed_q) begin
					count_q <= count_inc;
				end
			end else begin
				count_q <= '0;
			end
			if (press_hit) begin
				confirmed_q <= 1'b1;
			end else if (release_hit) begin
				confirmed_q <= 1'b0;
			end
			if (press_hit || release_hit) begin
				armed_q <= 1'b1;
			end
		end else if (clr_armed) begin
			armed_q <= 1'b0;
		end
	end

	assign lane_out.confirmed = confirmed_q;
	assign lane_out.armed = armed_q;
	assign lane_out.change = press_hit || release_hit;

endmodule
`default_nettype wire

// ===== hdl/gkdr_merge.sv =====
// merges lane changes into the pending key and answers service requests
`default_nettype none
module gkdr_merge (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic scan_en,
	input  wire logic srv_en,
	input  wire logic [gkdr_pkg::KEY_W-1:0] gate_key,
	input  gkdr_pkg::key_status_t status,
	output logic [gkdr_pkg::NUM_KEYS-1:0] clr_armed,
	output gkdr_pkg::result_t result
);
	import gkdr_pkg::*;

	logic [KEY_W-1:0] pending_q;
	logic [KEY_W-1:0] winner;
	logic any_change;
	logic [KEY_W-1:0] gate_m1;
	logic [KEY_W-1:0] pend_m1;
	logic [KEY_IDX_W-1:0] gate_idx;
	logic [KEY_IDX_W-1:0] pend_idx;
	logic gate_held;
	logic pend_ok;
	logic report;

	// highest changing key wins
	always_comb begin
		winner = '0;
		for (int i = 0; i < NUM_KEYS; i++) begin
			if (status.change[i]) begin
				winner = KEY_W'(i + 1);
			end
		end
	end

	assign any_change = |status.change;
	assign gate_m1 = gate_key - KEY_W'(1);
	assign pend_m1 = pending_q - KEY_W'(1);
	assign gate_idx = gate_m1[KEY_IDX_W-1:0];
	assign pend_idx = pend_m1[KEY_IDX_W-1:0];

	assign gate_held = (gate_key != '0) && (gate_key <= KEY_W'(NUM_KEYS))
		&& status.confirmed[gate_idx];
	assign pend_ok = (pending_q != '0) && (pending_q != gate_key)
		&& (pending_q <= KEY_W'(NUM_KEYS));
	assign report = srv_en && gate_held && pend_ok && status.armed[pend_idx];

	always_comb begin
		clr_armed = '0;
		if (report) begin
			clr_armed[pend_idx] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (scan_en && any_change) begin
			pending_q <= winner;
		end else if (srv_en && gate_held) begin
			pending_q <= '0;
		end
	end

	assign result.report_valid = report;
	assign result.key_code = report ? pending_q : '0;
	assign result.key_down = report && status.confirmed[pend_idx];

endmodule
`default_nettype wire

// ===== hdl/gkdr_checker.sv =====
// port-level checks for the gated key debounce reporter, bound to the top
`default_nettype none
module gkdr_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	input wire logic s_tready,
	input wire logic s_tuser,
	input wire logic m_tvalid,
	input wire logic m_tready,
	input wire logic [gkdr_pkg::M_TDATA_W-1:0] m_tdata
);
	import gkdr_pkg::*;

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// no report means all fields zero
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[RES_VALID_BIT] |->
			m_tdata[RES_CODE_LSB +: KEY_W] == '0 && !m_tdata[RES_DOWN_BIT])
		else $error("fields set without report");

	// a report always names a key
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[RES_VALID_BIT] |-> m_tdata[RES_CODE_LSB +: KEY_W] != '0)
		else $error("report with key code zero");

	// a scan request yields an empty result in the next cycle
	a_scan: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == CMD_SCAN |=> m_tvalid && !m_tdata[RES_VALID_BIT])
		else $error("scan did not give an empty result");

	// drained with nothing new accepted leaves the output empty
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !(s_tvalid && s_tready) |=> !m_tvalid)
		else $error("result repeated");

endmodule

bind gated_key_debounce_reporter_top gkdr_checker u_gkdr_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tuser(s_tuser),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata)
);
`default_nettype wire

// ===== sim/testbench.sv =====
// self-checking testbench for the gated key debounce reporter top level
module testbench;
	import gkdr_pkg::*;

	localparam int LIMIT = 400000;
	localparam int NUM_SETTINGS = 6;
	localparam int HOLD_CYCLES = 300;
	localparam logic [APB_ADDR_W-1:0] ADDR_THRESHOLD =
		APB_ADDR_W'(4 * int'(REG_PRESS_THRESHOLD));
	localparam logic [APB_ADDR_W-1:0] ADDR_GATE = APB_ADDR_W'(4 * int'(REG_GATE_KEY));

	typedef struct packed {
		logic cmd;
		logic [LEVELS_W-1:0] levels;
	} key_req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	gated_key_debounce_reporter_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// debounce state mirror
	logic [NUM_KEYS-1:0] key_down_q = '0;
	logic [NUM_KEYS-1:0] key_armed_q = '0;
	logic [CNT_W-1:0] key_count_q [NUM_KEYS] = '{default: '0};
	logic [KEY_W-1:0] pending_q = '0;
	logic [CNT_W-1:0] cfg_threshold = THRESHOLD_RESET;
	logic [KEY_W-1:0] cfg_gate = GATE_KEY_RESET;

	key_req_t request_q[$];
	result_t report_q[$];

	int n_issued = 0;
	int n_accepted = 0;
	int n_seen = 0;
	int n_reports = 0;
	int n_err = 0;
	int cycles = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	logic hold_req = 1'b0;
	logic hold_done = 1'b0;
	int hold_left = 0;

	int seg_thr [NUM_SETTINGS] = '{3, 0, 15, 1, 5, 2};
	int seg_gate [NUM_SETTINGS] = '{1, 15, 7, 0, 3, 12};

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("timeout after %0d cycles, %0d of %0d results seen", cycles, n_seen,
				n_issued);
			$display("[gated_key_debounce_reporter_top] ERROR");
			$finish;
		end
	end

	function automatic result_t debounce_step(logic cmd, logic [LEVELS_W-1:0] levels);
		result_t r;
		int k;
		int p;
		logic gate_on;
		r = '0;
		if (cmd == CMD_SCAN) begin
			for (k = 0; k < NUM_KEYS; k++) begin
				if (!levels[k]) begin
					if (!key_down_q[k]) begin
						if (key_count_q[k] != CNT_MAX)
							key_count_q[k] = key_count_q[k] + 1'b1;
						if (key_count_q[k] >= cfg_threshold) begin
							key_down_q[k] = 1'b1;
							key_armed_q[k] = 1'b1;
							pending_q = KEY_W'(k + 1);
						end
					end
				end else begin
					key_count_q[k] = '0;
					if (key_down_q[k]) begin
						key_down_q[k] = 1'b0;
						key_armed_q[k] = 1'b1;
						pending_q = KEY_W'(k + 1);
					end
				end
			end
		end else begin
			gate_on = 1'b0;
			if (cfg_gate != 0 && int'(cfg_gate) <= NUM_KEYS)
				gate_on = key_down_q[int'(cfg_gate) - 1];
			if (gate_on && pending_q != 0) begin
				p = int'(pending_q) - 1;
				if (pending_q != cfg_gate && key_armed_q[p]) begin
					key_armed_q[p] = 1'b0;
					r.report_valid = 1'b1;
					r.key_code = pending_q;
					r.key_down = key_down_q[p];
				end
				pending_q = '0;
			end
		end
		return r;
	endfunction

	task automatic flag_mismatch(string msg);
		$display("cycle %0d: mismatch: %s", cycles, msg);
		n_err++;
	endtask

	function automatic void add_item(logic cmd, logic [LEVELS_W-1:0] levels);
		key_req_t req;
		req.cmd = cmd;
		req.levels = levels;
		request_q.push_back(req);
		n_issued++;
	endfunction

	// steady runs (gate key mostly held) with bounce then services, or random items
	task automatic queue_random(int n);
		int stop;
		int run;
		int j;
		logic [LEVELS_W-1:0] pat;
		stop = n_issued + n;
		while (n_issued < stop) begin
			if ($urandom_range(9) == 0) begin
				add_item(1'($urandom_range(1)), LEVELS_W'($urandom));
			end else begin
				pat = '1;
				if (cfg_gate != 0 && $urandom_range(9) < 7)
					pat[int'(cfg_gate) - 1] = 1'b0;
				repeat ($urandom_range(3))
					pat[$urandom_range(NUM_KEYS - 1)] = 1'b0;
				run = $urandom_range(int'(cfg_threshold) + 2, 1);
				for (j = 0; j < run; j++) begin
					if ($urandom_range(9) == 0)
						add_item(CMD_SCAN, pat ^ (LEVELS_W'(1) << $urandom_range(NUM_KEYS - 1)));
					else
						add_item(CMD_SCAN, pat);
				end
				repeat ($urandom_range(2, 1))
					add_item(CMD_SERVICE, LEVELS_W'($urandom));
			end
		end
	endtask

	task automatic apb_write(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_config(int thr, int gate);
		apb_write(ADDR_THRESHOLD, APB_DATA_W'(thr));
		cfg_threshold = CNT_W'(thr);
		apb_write(ADDR_GATE, APB_DATA_W'(gate));
		cfg_gate = KEY_W'(gate);
	endtask

	always @(posedge clk) begin : drive
		key_req_t req;
		if (arst_n && (!s_tvalid || s_tready)) begin
			if (request_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				req = request_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {1'b0, req.levels};
				s_tuser <= req.cmd;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_done) begin
			m_tready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			report_q.push_back(debounce_step(s_tuser, s_tdata[LEVELS_W-1:0]));
			n_accepted++;
		end
	end

	always @(posedge clk) begin : check
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.report_valid = m_tdata[RES_VALID_BIT];
			got.key_code = m_tdata[RES_CODE_LSB +: KEY_W];
			got.key_down = m_tdata[RES_DOWN_BIT];
			n_seen++;
			if (got.report_valid)
				n_reports++;
			if (report_q.size() == 0) begin
				flag_mismatch($sformatf("result with nothing expected, tdata %h", m_tdata));
			end else begin
				want = report_q.pop_front();
				if (got.report_valid !== want.report_valid)
					flag_mismatch($sformatf("report_valid %b, expected %b",
						got.report_valid, want.report_valid));
				if (got.key_code !== want.key_code)
					flag_mismatch($sformatf("key_code %0d, expected %0d",
						got.key_code, want.key_code));
				if (got.key_down !== want.key_down)
					flag_mismatch($sformatf("key_down %b, expected %b",
						got.key_down, want.key_down));
			end
		end
	end

	initial begin : stimulus
		int seg;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		for (seg = 0; seg < NUM_SETTINGS; seg++) begin
			send_idle_pct = (seg < 2) ? 31 : (seg < 4) ? 62 : 0;
			recv_idle_pct = (seg < 2) ? 62 : (seg < 4) ? 31 : 0;
			if (seg > 0)
				set_config(seg_thr[seg], seg_gate[seg]);
			@(negedge clk);
			if (seg == 0) begin
				add_item(CMD_SERVICE, '0);
				add_item(CMD_SCAN, 15'h7fff);
				repeat (3) add_item(CMD_SCAN, 15'h0000);
				add_item(CMD_SERVICE, 15'h7fff);
				add_item(CMD_SERVICE, 15'h5555);
				add_item(CMD_SCAN, 15'h7ffe);
				add_item(CMD_SERVICE, 15'h2aaa);
				add_item(CMD_SCAN, 15'h7fff);
				repeat (3) add_item(CMD_SCAN, 15'h7ffe);
				// gate key itself pending
				add_item(CMD_SERVICE, '0);
				repeat (3) add_item(CMD_SCAN, 15'h3ffe);
				add_item(CMD_SERVICE, '0);
				add_item(CMD_SCAN, 15'h7fff);
				// gate released, pending kept
				add_item(CMD_SERVICE, '0);
			end
			queue_random(205);
			if (seg == 4)
				hold_req = 1'b1;
			while (n_seen < n_issued)
				@(negedge clk);
		end
		repeat (10) @(posedge clk);
		if (report_q.size() != 0)
			flag_mismatch($sformatf("%0d results never arrived", report_q.size()));
		$display("covered %0d requests (%0d accepted) over %0d register settings, %0d reports",
			n_issued, n_accepted, NUM_SETTINGS, n_reports);
		$display("thresholds 0 to 15, gate codes 0 to 15, one long output stall, %0d errors",
			n_err);
		if (n_err == 0) begin
			$display("[gated_key_debounce_reporter_top] OK");
		end else begin
			$display("[gated_key_debounce_reporter_top] ERROR");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hdl/gkdr_pkg.sv
hdl/gkdr_lane.sv
hdl/gkdr_merge.sv
hdl/gated_key_debounce_reporter_top.sv
hdl/gkdr_checker.sv
sim/testbench.sv
